FILE: rtl/pms_pkg.sv
// Shared types, codes and constants of the Post machine step block.
package pms_pkg;

  localparam int TAPE_CELLS_DEF    = 1024;
  localparam int PROGRAM_LINES_DEF = 256;

  localparam int KIND_W     = 3;
  localparam int ADDR_W     = 10;
  localparam int OP_W       = 3;
  localparam int LINE_W     = 9;
  localparam int STATUS_W   = 2;
  localparam int TLEN_W     = 11;
  localparam int PLEN_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = 1'd1;

  localparam logic [TLEN_W-1:0] TAPE_LEN_RST = 11'd1024;
  localparam logic [PLEN_W-1:0] PROG_LEN_RST = 9'd0;
  localparam logic [LINE_W-1:0] LINE_RST     = 9'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_TAPE  = 3'd0,
    KIND_WR_PROG  = 3'd1,
    KIND_SET_HEAD = 3'd2,
    KIND_STEP     = 3'd3,
    KIND_READ     = 3'd4
  } kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_TEST  = 3'd0,
    OP_RIGHT = 3'd1,
    OP_LEFT  = 3'd2,
    OP_ERASE = 3'd3,
    OP_MARK  = 3'd4,
    OP_PRINT = 3'd5,
    OP_HALT  = 3'd6,
    OP_BAD   = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN      = 2'd0,
    ST_HALT     = 2'd1,
    ST_LINE_ERR = 2'd2,
    ST_BAD_OP   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [LINE_W-1:0] target_a;
    logic [LINE_W-1:0] target_b;
  } line_t;

  // Write strobes and one-bit results of the step logic
  typedef struct packed {
    logic tape_we;
    logic tape_wd;
    logic prog_we;
    logic head_bit;
    logic read_bit;
  } exec_ctl_t;

endpackage

FILE: rtl/pms_tape_ram.sv
// Tape memory: one write port, two registered read ports with write bypass.
module pms_tape_ram #(
  parameter int  DEPTH = pms_pkg::TAPE_CELLS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic          rdata0,
  output logic          rdata1
);

  logic mem [DEPTH];
  logic q0_r;
  logic q1_r;
  logic fwd0_r;
  logic fwd1_r;
  logic wd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q0_r   <= mem[raddr0];
    q1_r   <= mem[raddr1];
    fwd0_r <= we && (waddr == raddr0);
    fwd1_r <= we && (waddr == raddr1);
    wd_r   <= wdata;
  end

  // take the new value when the same cell was written during the read
  assign rdata0 = fwd0_r ? wd_r : q0_r;
  assign rdata1 = fwd1_r ? wd_r : q1_r;

endmodule

FILE: rtl/pms_prog_ram.sv
// Program memory: one write port, one registered read port with write bypass.
module pms_prog_ram #(
  parameter int  DEPTH = pms_pkg::PROGRAM_LINES_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  pms_pkg::line_t wdata,
  input  logic [AW-1:0]  raddr,
  output pms_pkg::line_t rdata
);

  import pms_pkg::*;

  line_t mem [DEPTH];
  line_t q_r;
  line_t wd_r;
  logic  fwd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r   <= mem[raddr];
    fwd_r <= we && (waddr == raddr);
    wd_r  <= wdata;
  end

  assign rdata = fwd_r ? wd_r : q_r;

endmodule

FILE: rtl/pms_exec.sv
// Step logic: next machine state and memory writes for one request.
module pms_exec #(
  parameter int  TAPE_CELLS    = pms_pkg::TAPE_CELLS_DEF,
  parameter int  PROGRAM_LINES = pms_pkg::PROGRAM_LINES_DEF,
  localparam int HEAD_W        = $clog2(TAPE_CELLS),
  localparam int PIDX_W        = $clog2(PROGRAM_LINES)
) (
  input  logic [pms_pkg::KIND_W-1:0] kind,
  input  logic [pms_pkg::ADDR_W-1:0] addr,
  input  logic                       bit_value,
  input  logic [pms_pkg::OP_W-1:0]   opcode,
  input  logic [pms_pkg::LINE_W-1:0] target_a,
  input  logic [pms_pkg::LINE_W-1:0] target_b,
  input  logic [pms_pkg::TLEN_W-1:0] tape_len,
  input  logic [pms_pkg::PLEN_W-1:0] prog_len,
  input  logic [HEAD_W-1:0]          head,
  input  logic [pms_pkg::LINE_W-1:0] line,
  input  pms_pkg::status_t           status,
  input  logic                       head_bit,
  input  pms_pkg::line_t             pline,
  input  logic                       rd0,
  input  logic                       rd1,
  output logic [HEAD_W-1:0]          head_nxt,
  output logic [pms_pkg::LINE_W-1:0] line_nxt,
  output pms_pkg::status_t           status_nxt,
  output pms_pkg::exec_ctl_t         ctl,
  output logic [HEAD_W-1:0]          tape_waddr,
  output logic [PIDX_W-1:0]          prog_waddr,
  output pms_pkg::line_t             prog_wdata
);

  import pms_pkg::*;

  localparam int LEN_W = $clog2(TAPE_CELLS + 1);
  localparam int PL_W  = $clog2(PROGRAM_LINES + 1);

  logic [LEN_W-1:0]  eff_len;
  logic [PL_W-1:0]   eff_prog;
  logic [HEAD_W:0]   head_inc;
  logic              tape_in_range;
  logic              prog_in_range;
  logic              line_bad;
  logic [LINE_W-1:0] ta_fix;

  always_comb begin
    if (tape_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (tape_len > TAPE_CELLS) begin
      eff_len = LEN_W'(TAPE_CELLS);
    end else begin
      eff_len = LEN_W'(tape_len);
    end
    if (prog_len > PROGRAM_LINES) begin
      eff_prog = PL_W'(PROGRAM_LINES);
    end else begin
      eff_prog = PL_W'(prog_len);
    end
  end

  assign head_inc      = {1'b0, head} + (HEAD_W + 1)'(1);
  assign tape_in_range = addr < TAPE_CELLS;
  assign prog_in_range = (addr != '0) && (addr <= PROGRAM_LINES);
  assign line_bad      = (line == '0) || (line > eff_prog);
  // a zero next line falls through to the following line
  assign ta_fix        = (target_a == '0) ? LINE_W'(addr + 10'd1) : target_a;

  always_comb begin
    head_nxt     = head;
    line_nxt     = line;
    status_nxt   = status;
    ctl          = '0;
    ctl.head_bit = head_bit;
    tape_waddr   = head;
    prog_waddr   = PIDX_W'(addr - 10'd1);
    prog_wdata   = '{op: op_t'(opcode), target_a: ta_fix, target_b: target_b};
    unique case (kind_t'(kind))
      KIND_WR_TAPE: begin
        if (tape_in_range) begin
          ctl.tape_we = 1'b1;
          ctl.tape_wd = bit_value;
          tape_waddr  = HEAD_W'(addr);
          if (addr == head) begin
            ctl.head_bit = bit_value;
          end
        end
      end
      KIND_WR_PROG: begin
        ctl.prog_we = prog_in_range;
      end
      KIND_SET_HEAD: begin
        if (addr < eff_len) begin
          head_nxt     = HEAD_W'(addr);
          ctl.head_bit = rd0;
        end
      end
      KIND_STEP: begin
        if (status == ST_RUN) begin
          if (line_bad) begin
            status_nxt = ST_LINE_ERR;
          end else begin
            unique case (pline.op)
              OP_TEST: begin
                line_nxt = head_bit ? pline.target_b : pline.target_a;
              end
              OP_RIGHT: begin
                if (head_inc < eff_len) begin
                  head_nxt     = head_inc[HEAD_W-1:0];
                  ctl.head_bit = rd1;
                end
                line_nxt = pline.target_a;
              end
              OP_LEFT: begin
                if (head != '0) begin
                  head_nxt     = head - HEAD_W'(1);
                  ctl.head_bit = rd0;
                end
                line_nxt = pline.target_a;
              end
              OP_ERASE: begin
                ctl.tape_we  = 1'b1;
                ctl.tape_wd  = 1'b0;
                ctl.head_bit = 1'b0;
                line_nxt     = pline.target_a;
              end
              OP_MARK: begin
                ctl.tape_we  = 1'b1;
                ctl.tape_wd  = 1'b1;
                ctl.head_bit = 1'b1;
                line_nxt     = pline.target_a;
              end
              OP_PRINT: begin
                line_nxt = pline.target_a;
              end
              OP_HALT: begin
                status_nxt = ST_HALT;
              end
              OP_BAD: begin
                status_nxt = ST_BAD_OP;
              end
            endcase
          end
        end
      end
      KIND_READ: begin
        ctl.read_bit = tape_in_range & rd0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/post_machine_step.sv
// Top level of the Post machine step block.
//
// Each request writes a tape cell, writes a program line, sets the head,
// executes the command at the current line, or reads a tape cell, and each
// produces exactly one result with the status, head position, mark under the
// head, next line and (for a read) the addressed mark. The block takes one
// request per clock cycle sustained while out_stall does not hold the output
// register; a request is registered in the input register and its result in
// the output register. The tape and program memories are synchronous, so
// their read addresses are driven from the next-state head and line, so the
// program line and the two neighbor cells of the head (or the addressed
// cell for a read or set-head request) are ready when the request sits in
// the input register. The mark under the head is kept in a register of its
// own, so a step needs no third tape port. Status is sticky: once halted or
// in error, steps change nothing until reset. Tape and program memories
// power up undefined and are not cleared; read only what was written.
// Configuration writes are taken at any time but belong in idle periods.
module post_machine_step #(
  parameter int TAPE_CELLS    = pms_pkg::TAPE_CELLS_DEF,
  parameter int PROGRAM_LINES = pms_pkg::PROGRAM_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pms_pkg::KIND_W-1:0]     in_kind,
  input  logic [pms_pkg::ADDR_W-1:0]     in_addr,
  input  logic                           in_bit_value,
  input  logic [pms_pkg::OP_W-1:0]       in_opcode,
  input  logic [pms_pkg::LINE_W-1:0]     in_target_a,
  input  logic [pms_pkg::LINE_W-1:0]     in_target_b,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pms_pkg::STATUS_W-1:0]   out_status,
  output logic [pms_pkg::ADDR_W-1:0]     out_head_position,
  output logic                           out_head_bit,
  output logic [pms_pkg::LINE_W-1:0]     out_current_line,
  output logic                           out_read_bit
);

  import pms_pkg::*;

  localparam int HEAD_W = $clog2(TAPE_CELLS);
  localparam int PIDX_W = $clog2(PROGRAM_LINES);

  // configuration
  logic [TLEN_W-1:0] tape_len_r;
  logic [PLEN_W-1:0] prog_len_r;

  // input register
  logic              ir_valid_r;
  logic [KIND_W-1:0] ir_kind_r;
  logic [ADDR_W-1:0] ir_addr_r;
  logic              ir_bit_r;
  logic [OP_W-1:0]   ir_op_r;
  logic [LINE_W-1:0] ir_ta_r;
  logic [LINE_W-1:0] ir_tb_r;

  // machine state
  logic [HEAD_W-1:0] head_r;
  logic [LINE_W-1:0] line_r;
  status_t           status_r;
  logic              hb_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_head_r;
  logic                out_hb_r;
  logic [LINE_W-1:0]   out_line_r;
  logic                out_rd_r;

  // handshake
  logic fire;
  logic in_acc;
  logic out_acc;

  // step logic results
  logic [HEAD_W-1:0] x_head;
  logic [LINE_W-1:0] x_line;
  status_t           x_status;
  exec_ctl_t         x_ctl;
  logic [HEAD_W-1:0] x_tape_waddr;
  logic [PIDX_W-1:0] x_prog_waddr;
  line_t             x_prog_wdata;

  logic [HEAD_W-1:0] head_nxt;
  logic [LINE_W-1:0] line_nxt;

  // memory ports
  logic [KIND_W-1:0] nk;
  logic [ADDR_W-1:0] na;
  logic [HEAD_W-1:0] tape_raddr0;
  logic [HEAD_W-1:0] tape_raddr1;
  logic              tape_rd0;
  logic              tape_rd1;
  logic [PIDX_W-1:0] prog_raddr;
  line_t             prog_rdata;

  // advance the input register whenever the output register can take a result
  assign fire     = ir_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = ir_valid_r && !fire;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  assign head_nxt = fire ? x_head : head_r;
  assign line_nxt = fire ? x_line : line_r;

  // the request that will sit in the input register next cycle
  assign nk = in_acc ? in_kind : ir_kind_r;
  assign na = in_acc ? in_addr : ir_addr_r;

  // port 0 fetches the addressed cell for set-head and read, else the left
  // neighbor; port 1 always fetches the right neighbor
  assign tape_raddr0 = ((nk == KIND_SET_HEAD) || (nk == KIND_READ)) ?
                       HEAD_W'(na) : head_nxt - HEAD_W'(1);
  assign tape_raddr1 = head_nxt + HEAD_W'(1);
  assign prog_raddr  = PIDX_W'(line_nxt - LINE_W'(1));

  pms_exec #(
    .TAPE_CELLS    (TAPE_CELLS),
    .PROGRAM_LINES (PROGRAM_LINES)
  ) u_exec (
    .kind       (ir_kind_r),
    .addr       (ir_addr_r),
    .bit_value  (ir_bit_r),
    .opcode     (ir_op_r),
    .target_a   (ir_ta_r),
    .target_b   (ir_tb_r),
    .tape_len   (tape_len_r),
    .prog_len   (prog_len_r),
    .head       (head_r),
    .line       (line_r),
    .status     (status_r),
    .head_bit   (hb_r),
    .pline      (prog_rdata),
    .rd0        (tape_rd0),
    .rd1        (tape_rd1),
    .head_nxt   (x_head),
    .line_nxt   (x_line),
    .status_nxt (x_status),
    .ctl        (x_ctl),
    .tape_waddr (x_tape_waddr),
    .prog_waddr (x_prog_waddr),
    .prog_wdata (x_prog_wdata)
  );

  pms_tape_ram #(
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk    (clk),
    .we     (fire && x_ctl.tape_we),
    .waddr  (x_tape_waddr),
    .wdata  (x_ctl.tape_wd),
    .raddr0 (tape_raddr0),
    .raddr1 (tape_raddr1),
    .rdata0 (tape_rd0),
    .rdata1 (tape_rd1)
  );

  pms_prog_ram #(
    .DEPTH (PROGRAM_LINES)
  ) u_prog (
    .clk   (clk),
    .we    (fire && x_ctl.prog_we),
    .waddr (x_prog_waddr),
    .wdata (x_prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  // control state, configuration and machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_len_r  <= TAPE_LEN_RST;
      prog_len_r  <= PROG_LEN_RST;
      ir_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      line_r      <= LINE_RST;
      status_r    <= ST_RUN;
      hb_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TAPE_LEN: tape_len_r <= cfg_wdata;
          CFG_PROG_LEN: prog_len_r <= cfg_wdata[PLEN_W-1:0];
          default: begin
          end
        endcase
      end
      // hold the input register while the result side is blocked
      if (in_acc) begin
        ir_valid_r <= 1'b1;
      end else if (fire) begin
        ir_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      head_r <= head_nxt;
      line_r <= line_nxt;
      if (fire) begin
        status_r <= x_status;
        hb_r     <= x_ctl.head_bit;
      end
    end
  end

  // request and result payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ir_kind_r <= in_kind;
      ir_addr_r <= in_addr;
      ir_bit_r  <= in_bit_value;
      ir_op_r   <= in_opcode;
      ir_ta_r   <= in_target_a;
      ir_tb_r   <= in_target_b;
    end
    if (fire) begin
      out_status_r <= x_status;
      out_head_r   <= ADDR_W'(x_head);
      out_hb_r     <= x_ctl.head_bit;
      out_line_r   <= x_line;
      out_rd_r     <= x_ctl.read_bit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_position = out_head_r;
  assign out_head_bit      = out_hb_r;
  assign out_current_line  = out_line_r;
  assign out_read_bit      = out_rd_r;

endmodule

FILE: rtl/pms_checker.sv
// Port-level checks of the Post machine step block, bound to its top level.
module pms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [9:0] out_head_position,
  input logic       out_head_bit,
  input logic [8:0] out_current_line,
  input logic       out_read_bit
);

  logic [1:0] pend_r;
  logic [1:0] last_st_r;
  logic [8:0] last_line_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // track requests in flight and the last delivered status and line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      last_st_r   <= '0;
      last_line_r <= '0;
    end else begin
      pend_r <= 2'(pend_r + 2'(in_acc) - 2'(out_acc));
      if (out_acc) begin
        last_st_r   <= out_status;
        last_line_r <= out_current_line;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_head_position) && $stable(out_head_bit) &&
      $stable(out_current_line) && $stable(out_read_bit)))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid || in_stall) |-> ((pend_r != 2'd0) && (pend_r != 2'd3)))
    else $error("result without a pending request or too many in flight");

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (last_st_r != 2'd0)) |-> (out_status == last_st_r))
    else $error("status left halt or error before reset");

  a_line_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (last_st_r != 2'd0)) |-> (out_current_line == last_line_r))
    else $error("line moved while machine stopped");

endmodule

bind post_machine_step pms_checker u_pms_checker (.*);

FILE: dv/post_machine_step_tb.sv
// Self-checking testbench for the Post machine step block.
`timescale 1ns / 100ps

module post_machine_step_tb;
  import pms_pkg::*;

  localparam int NUM_CELLS     = TAPE_CELLS_DEF;
  localparam int NUM_LINES     = PROGRAM_LINES_DEF;
  localparam int KIND_TOP      = (1 << KIND_W) - 1;
  localparam int ADDR_TOP      = (1 << ADDR_W) - 1;
  localparam int LINE_TOP      = (1 << LINE_W) - 1;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int CYCLE_LIMIT   = 400000;

  // One request as it crosses the input channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic              bitv;
    logic [OP_W-1:0]   op;
    logic [LINE_W-1:0] ta;
    logic [LINE_W-1:0] tb;
  } request_t;

  // Machine state reported after each request
  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] head;
    logic              hbit;
    logic [LINE_W-1:0] line;
    logic              rbit;
  } report_t;

  // Ways to end the run; the status is sticky, so only one fits in a run
  typedef enum int {
    END_HALT,
    END_BAD_OP,
    END_PAST_LAST,
    END_NO_LINES,
    END_LINE_ZERO
  } ending_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind      = '0;
  logic [ADDR_W-1:0]     in_addr      = '0;
  logic                  in_bit_value = 1'b0;
  logic [OP_W-1:0]       in_opcode    = '0;
  logic [LINE_W-1:0]     in_target_a  = '0;
  logic [LINE_W-1:0]     in_target_b  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_head_position;
  logic                  out_head_bit;
  logic [LINE_W-1:0]     out_current_line;
  logic                  out_read_bit;

  // Request stream, expected reports and bookkeeping
  request_t request_q[$];
  report_t  pending_reports[$];
  int       requests_in_flight = 0;
  int       err_cnt            = 0;
  int       cycle_count        = 0;
  int       send_idle_pct      = 19;
  int       recv_idle_pct      = 52;

  // Predicted machine: tape, program store, head, line, status, registers
  logic              tape_img [NUM_CELLS];
  op_t               cmd_op   [NUM_LINES];
  logic [LINE_W-1:0] cmd_ta   [NUM_LINES];
  logic [LINE_W-1:0] cmd_tb   [NUM_LINES];
  logic [ADDR_W-1:0] mach_head    = '0;
  logic [LINE_W-1:0] mach_line    = LINE_RST;
  status_t           mach_status  = ST_RUN;
  logic [TLEN_W-1:0] tape_len_reg = TAPE_LEN_RST;
  logic [PLEN_W-1:0] prog_len_reg = PROG_LEN_RST;

  post_machine_step u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_addr           (in_addr),
    .in_bit_value      (in_bit_value),
    .in_opcode         (in_opcode),
    .in_target_a       (in_target_a),
    .in_target_b       (in_target_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_head_position (out_head_position),
    .out_head_bit      (out_head_bit),
    .out_current_line  (out_current_line),
    .out_read_bit      (out_read_bit)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Tape cells in use: zero acts as one, anything past the tape as the tape
  function automatic int unsigned tape_span();
    if (tape_len_reg == '0) return 1;
    if (tape_len_reg > NUM_CELLS) return NUM_CELLS;
    return tape_len_reg;
  endfunction

  // Apply one accepted request to the predicted machine and report its state
  function automatic report_t next_report(request_t r);
    report_t           rep;
    logic [LINE_W-1:0] ta;
    logic              rd;
    int unsigned       span;
    int unsigned       lines;
    int unsigned       idx;
    rd    = 1'b0;
    span  = tape_span();
    lines = (prog_len_reg > NUM_LINES) ? NUM_LINES : prog_len_reg;
    case (r.kind)
      KIND_WR_TAPE: tape_img[r.addr] = r.bitv;
      KIND_WR_PROG: begin
        // Line zero and lines past the store are dropped
        if (r.addr != '0 && r.addr <= NUM_LINES) begin
          // A zero next line means fall through to the following line
          ta = (r.ta == '0) ? r.addr[LINE_W-1:0] + 1'b1 : r.ta;
          cmd_op[r.addr - 1] = op_t'(r.op);
          cmd_ta[r.addr - 1] = ta;
          cmd_tb[r.addr - 1] = r.tb;
        end
      end
      KIND_SET_HEAD: if (r.addr < span) mach_head = r.addr;
      KIND_STEP: begin
        // Sticky status: a halted or failed machine ignores steps
        if (mach_status == ST_RUN) begin
          if (mach_line == '0 || mach_line > lines) begin
            mach_status = ST_LINE_ERR;
          end else begin
            idx = mach_line - 1;
            case (cmd_op[idx])
              OP_TEST:  mach_line = tape_img[mach_head] ? cmd_tb[idx] : cmd_ta[idx];
              OP_RIGHT: begin
                // Clamp at the end; a head past a shortened tape stays put
                if (mach_head + 1 < span) mach_head = mach_head + 1'b1;
                mach_line = cmd_ta[idx];
              end
              OP_LEFT: begin
                if (mach_head != '0) mach_head = mach_head - 1'b1;
                mach_line = cmd_ta[idx];
              end
              OP_ERASE: begin
                tape_img[mach_head] = 1'b0;
                mach_line = cmd_ta[idx];
              end
              OP_MARK: begin
                tape_img[mach_head] = 1'b1;
                mach_line = cmd_ta[idx];
              end
              OP_PRINT: mach_line = cmd_ta[idx];
              OP_HALT:  mach_status = ST_HALT;
              default:  mach_status = ST_BAD_OP;
            endcase
          end
        end
      end
      KIND_READ: rd = tape_img[r.addr];
      default: ;
    endcase
    rep.status = mach_status;
    rep.head   = mach_head;
    rep.hbit   = tape_img[mach_head];
    rep.line   = mach_line;
    rep.rbit   = rd;
    return rep;
  endfunction

  // Request of the given kind, every field it does not use left random
  function automatic request_t rand_req(logic [KIND_W-1:0] k);
    request_t r;
    r.kind = k;
    r.addr = $urandom;
    r.bitv = $urandom;
    r.op   = $urandom;
    r.ta   = $urandom;
    r.tb   = $urandom;
    return r;
  endfunction

  function automatic request_t addr_req(logic [KIND_W-1:0] k, int unsigned a);
    request_t r;
    r      = rand_req(k);
    r.addr = a;
    return r;
  endfunction

  function automatic request_t prog_req(int unsigned line, op_t op, int unsigned ta,
                                        int unsigned tb);
    request_t r;
    r      = addr_req(KIND_WR_PROG, line);
    r.op   = op;
    r.ta   = ta;
    r.tb   = tb;
    return r;
  endfunction

  // Program line that keeps the machine running: lines up to lim jump within
  // 1..lim, higher lines within the whole store; no halt, no bad opcode.
  function automatic request_t line_req(int unsigned line, int unsigned lim);
    request_t    r;
    int unsigned hi;
    hi = (line <= lim) ? lim : NUM_LINES;
    r  = prog_req(line, op_t'($urandom_range(OP_TEST, OP_PRINT)), $urandom_range(1, hi),
                  $urandom);
    // Zero next line only where the following line is still in range
    if (line < hi && $urandom_range(0, 7) == 0) r.ta = '0;
    if (r.op == OP_TEST) r.tb = $urandom_range(1, hi);
    return r;
  endfunction

  task automatic send(request_t r);
    request_q.push_back(r);
    requests_in_flight++;
  endtask

  // Hold until every request is taken and every report has come back
  task automatic wait_drain();
    while (requests_in_flight != 0 || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TAPE_LEN) tape_len_reg = val;
    else prog_len_reg = val;
  endtask

  // Random mix of requests; steps only when lines 1..lim are safe to run
  task automatic mix_requests(int unsigned count, int unsigned lim);
    request_t    r;
    int unsigned pick;
    int unsigned span;
    span = tape_span();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && lim != 0) begin
        r = rand_req(KIND_STEP);
      end else if (pick < 55) begin
        r = rand_req(KIND_WR_TAPE);
      end else if (pick < 68) begin
        r = rand_req(KIND_READ);
      end else if (pick < 80) begin
        // Half the head moves land on the tape in use, the rest anywhere
        r = rand_req(KIND_SET_HEAD);
        if ($urandom_range(0, 1) != 0) r.addr = $urandom_range(0, span - 1);
      end else if (pick < 93) begin
        if ($urandom_range(0, 9) == 0) begin
          // Dropped write: line zero or past the store, any content
          r = rand_req(KIND_WR_PROG);
          r.addr = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(NUM_LINES + 1, ADDR_TOP);
        end else if (lim != 0 && $urandom_range(0, 1) != 0) begin
          r = line_req($urandom_range(1, lim), lim);
        end else begin
          r = line_req($urandom_range(1, NUM_LINES), lim);
        end
      end else begin
        r = rand_req($urandom_range(KIND_READ + 1, KIND_TOP));
      end
      send(r);
    end
  endtask

  task automatic run_phase(int unsigned tlen, int unsigned plen, int unsigned count);
    wait_drain();
    write_reg(CFG_TAPE_LEN, tlen);
    write_reg(CFG_PROG_LEN, plen);
    mix_requests(count, (plen > NUM_LINES) ? NUM_LINES : plen);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Request driver: predict each accepted request, then offer the next one.
  // Hold the payload while stalled; idle at random only between requests.
  always @(posedge clk) begin
    request_t taken;
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = '{in_kind, in_addr, in_bit_value, in_opcode, in_target_a, in_target_b};
        pending_reports.push_back(next_report(taken));
        requests_in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt           = request_q.pop_front();
          in_kind      <= nxt.kind;
          in_addr      <= nxt.addr;
          in_bit_value <= nxt.bitv;
          in_opcode    <= nxt.op;
          in_target_a  <= nxt.ta;
          in_target_b  <= nxt.tb;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: check each accepted report against the oldest prediction
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: report with no request waiting, status %0d head %0d line %0d",
                   $time, out_status, out_head_position, out_current_line);
          err_cnt++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("head_position", want.head, out_head_position);
          compare_field("head_bit", want.hbit, out_head_bit);
          compare_field("current_line", want.line, out_current_line);
          compare_field("read_bit", want.rbit, out_read_bit);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    request_t    r;
    int unsigned cur;
    int unsigned lim;
    ending_t     ending;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole tape, cell zero first since the head sits there, then
    // every program line, so nothing is ever read before it is written.
    for (int i = 0; i < NUM_CELLS; i++) send(addr_req(KIND_WR_TAPE, i));
    for (int i = 1; i <= NUM_LINES; i++) send(line_req(i, NUM_LINES));
    wait_drain();
    write_reg(CFG_PROG_LEN, NUM_LINES);

    // Directed: dropped program writes, then a short program that walks every
    // command once: right clamped at the tape end, left, mark, test on a mark,
    // erase, test on a blank, print to the last line, left clamped at zero.
    send(prog_req(0, OP_BAD, LINE_TOP, LINE_TOP));
    send(prog_req(ADDR_TOP, OP_HALT, 0, 0));
    send(prog_req(1, OP_RIGHT, 0, 0));
    send(prog_req(2, OP_LEFT, 3, 0));
    send(prog_req(3, OP_MARK, 4, 0));
    send(prog_req(4, OP_TEST, 5, 6));
    send(prog_req(6, OP_ERASE, 7, 0));
    send(prog_req(7, OP_TEST, 8, 5));
    send(prog_req(8, OP_PRINT, NUM_LINES, 0));
    send(prog_req(NUM_LINES, OP_LEFT, 2, 0));
    send(addr_req(KIND_SET_HEAD, NUM_CELLS - 1));
    repeat (8) send(rand_req(KIND_STEP));
    send(addr_req(KIND_SET_HEAD, 0));
    send(rand_req(KIND_STEP));
    send(addr_req(KIND_READ, 0));
    r      = addr_req(KIND_WR_TAPE, NUM_CELLS - 1);
    r.bitv = 1'b1;
    send(r);
    send(addr_req(KIND_READ, NUM_CELLS - 1));
    for (int k = KIND_READ + 1; k <= KIND_TOP; k++) send(rand_req(k));

    // Random phases over tape and program lengths, extremes included
    run_phase(NUM_CELLS, NUM_LINES, 90);
    run_phase((1 << TLEN_W) - 1, (1 << PLEN_W) - 1, 90);

    send_idle_pct = 52;
    recv_idle_pct = 19;
    // Shortened tape: the head is often left past its end
    run_phase($urandom_range(2, NUM_CELLS - 1), NUM_LINES, 90);
    run_phase(1, 300, 90);
    // Zero lengths: no step may run with an empty program
    run_phase(0, 0, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Short program: restore the full program, jump to line one, then
    // shrink and rewrite every line so the machine loops inside it.
    run_phase($urandom_range(2, NUM_CELLS), NUM_LINES, 0);
    send(prog_req(mach_line, OP_PRINT, 1, $urandom));
    send(rand_req(KIND_STEP));
    lim = $urandom_range(2, 16);
    run_phase(tape_len_reg, lim, 0);
    for (int i = 1; i <= lim; i++) send(line_req(i, lim));
    mix_requests(90, lim);

    run_phase(NUM_CELLS, NUM_LINES, 90);

    // Stop the machine one way, then show that steps no longer change it
    wait_drain();
    cur    = mach_line;
    ending = ending_t'($urandom_range(END_HALT, END_LINE_ZERO));
    case (ending)
      END_HALT:   send(prog_req(cur, OP_HALT, $urandom, $urandom));
      END_BAD_OP: send(prog_req(cur, OP_BAD, $urandom, $urandom));
      END_PAST_LAST: begin
        // The last line falls through to one past the store
        if (cur != NUM_LINES) send(prog_req(cur, OP_PRINT, NUM_LINES, $urandom));
        send(prog_req(NUM_LINES, OP_PRINT, 0, $urandom));
      end
      END_NO_LINES: write_reg(CFG_PROG_LEN, 0);
      END_LINE_ZERO: begin
        // Branch on a marked cell to line zero
        r      = addr_req(KIND_WR_TAPE, mach_head);
        r.bitv = 1'b1;
        send(r);
        send(prog_req(cur, OP_TEST, $urandom_range(1, NUM_LINES), 0));
      end
      default: ;
    endcase
    repeat (3) send(rand_req(KIND_STEP));
    mix_requests(24, NUM_LINES);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pms_pkg.sv
rtl/pms_tape_ram.sv
rtl/pms_prog_ram.sv
rtl/pms_exec.sv
rtl/post_machine_step.sv
rtl/pms_checker.sv
dv/post_machine_step_tb.sv
